### rtl/qss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quicksort sorter unit.
// No dependencies; imported by qss_cell and quicksort_sorter_unit.
package qss_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		data_t value;
		logic  last;
	} item_t;

	typedef struct packed {
		data_t sorted_value;
		logic  final_res;
	} result_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic insert;   // place the new value, shift larger entries right
		logic drain;    // shift all entries one place toward cell 0
	} ctl_t;

endpackage

### rtl/qss_cell.sv
`timescale 1ns / 1ps
// One cell of the sorting chain: holds one value and its valid flag.
// Depends on qss_pkg.
module qss_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  qss_pkg::ctl_t ctl,
	input  qss_pkg::data_t x,
	input  qss_pkg::data_t left_value,
	input  logic          left_valid,
	input  logic          left_take,
	input  qss_pkg::data_t right_value,
	input  logic          right_valid,
	output qss_pkg::data_t value,
	output logic          valid,
	output logic          take
);
	import qss_pkg::*;

	data_t value_q;
	logic  valid_q;

	// empty cells and cells holding a larger value move right on insert
	assign take  = !valid_q || (x < value_q);
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (take) begin
				value_q <= left_take ? left_value : x;
			end
		end else if (ctl.drain) begin
			value_q <= right_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= valid_q | left_valid;
		end else if (ctl.drain) begin
			valid_q <= right_valid;
		end
	end

endmodule

### rtl/quicksort_sorter_unit.sv
`timescale 1ns / 1ps
// Batch sorter top level: a chain of DEPTH sorting cells plus drain control.
// Depends on qss_pkg and qss_cell.
//
// Usage:
//   item channel (item_valid/item_ready/item): one signed value per transfer,
//   item.last marks the end of a batch. Each transfer inserts its value into
//   the cell chain in sorted position in that same cycle, so loading runs at
//   one item per cycle. Values beyond DEPTH are dropped; a dropped item that
//   carries last still closes the batch.
//   result channel (result_valid/result_ready/result): after the last item,
//   the stored values come out smallest first, one per transfer, with
//   result.final_res set on the largest one. The first result is valid in
//   the cycle after the last item's transfer; results can transfer back to
//   back when the receiver does not stall.
//   item_ready is low from the last item's transfer until the final result
//   transfers, so the loading and the draining of a batch never overlap.
//   A stall on result_ready simply holds the chain; cell 0 is the output
//   register and keeps its value until taken.
//   Reset clears all valid flags and the drain flag: the chain is empty and
//   ready for a new batch. Stored values are not reset.
module quicksort_sorter_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  qss_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output qss_pkg::result_t result
);
	import qss_pkg::*;

	logic  drain_q;
	ctl_t  ctl;
	data_t cell_value [DEPTH];
	logic  cell_valid [DEPTH];
	logic  cell_take  [DEPTH];
	logic  item_xfer;
	logic  result_xfer;
	logic  full;
	logic  is_final;

	assign full        = cell_valid[DEPTH-1];
	assign item_ready  = !drain_q;
	assign item_xfer   = item_valid && item_ready;
	assign result_xfer = result_valid && result_ready;

	assign ctl.insert = item_xfer && !full;
	assign ctl.drain  = result_xfer;

	// cell 0 always holds the smallest remaining value while draining
	assign is_final            = !cell_valid[1];
	assign result_valid        = drain_q;
	assign result.sorted_value = cell_value[0];
	assign result.final_res    = is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
		end else if (item_xfer && item.last) begin
			drain_q <= 1'b1;
		end else if (result_xfer && is_final) begin
			drain_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t lv, rv;
		logic  lvld, ltake, rvld;

		if (i == 0) begin : g_head
			// head cell: nothing to its left, it always fills first
			assign lv    = item.value;
			assign lvld  = 1'b1;
			assign ltake = 1'b0;
		end else begin : g_body
			assign lv    = cell_value[i-1];
			assign lvld  = cell_valid[i-1];
			assign ltake = cell_take[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign rv   = '0;
			assign rvld = 1'b0;
		end else begin : g_inner
			assign rv   = cell_value[i+1];
			assign rvld = cell_valid[i+1];
		end

		qss_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.x           (item.value),
			.left_value  (lv),
			.left_valid  (lvld),
			.left_take   (ltake),
			.right_value (rv),
			.right_valid (rvld),
			.value       (cell_value[i]),
			.valid       (cell_valid[i]),
			.take        (cell_take[i])
		);
	end

endmodule

### tb/sv/quicksort_sorter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for quicksort_sorter_unit: batches go in, each result is checked
// in order against a sorted copy kept by the bench. Depends on qss_pkg and the RTL.
module quicksort_sorter_unit_test;
	import qss_pkg::*;

	localparam int RANDOM_ITEMS = 55;
	localparam int DRAIN_CYCLES = 20;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// Values of the open batch, kept in ascending order. A value that finds
	// the batch already DEPTH long is dropped, the same as the hardware does.
	data_t   open_batch[$];
	// Results still owed by the block, oldest first.
	result_t owed_results[$];

	int mismatch_count = 0;
	int burst_left     = 0;
	int ready_mode     = 0;
	int ready_hold     = 0;

	quicksort_sorter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs on either channel.
	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Fold one accepted item into the open batch. An item marked last closes
	// the batch: its sorted contents become the owed results, and only the
	// largest one carries final_res.
	function automatic void account_item(item_t it);
		int      pos;
		result_t r;
		if (open_batch.size() < DEPTH) begin
			pos = 0;
			while (pos < open_batch.size() && open_batch[pos] <= it.value)
				pos++;
			open_batch.insert(pos, it.value);
		end
		if (it.last) begin
			foreach (open_batch[k]) begin
				r.sorted_value = open_batch[k];
				r.final_res    = (k == open_batch.size() - 1);
				owed_results.push_back(r);
			end
			open_batch.delete();
		end
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (owed_results.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual value %0d final %0b",
				$time, got.sorted_value, got.final_res);
			mismatch_count++;
			return;
		end
		want = owed_results.pop_front();
		if (got.sorted_value !== want.sorted_value) begin
			$display("%0t: sorted_value: expected %0d, actual %0d",
				$time, want.sorted_value, got.sorted_value);
			mismatch_count++;
		end
		if (got.final_res !== want.final_res) begin
			$display("%0t: final_res: expected %0b, actual %0b",
				$time, want.final_res, got.final_res);
			mismatch_count++;
		end
	endfunction

	// Result side: check each transfer, then pick the next ready level.
	// The stall pattern switches between free flow, coin-flip stalls and long
	// stalls, holding each mode for a random number of cycles so that stalls
	// land both early and late in a drain.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			check_result(result);
		if (ready_hold == 0) begin
			ready_mode = $urandom_range(0, 2);
			ready_hold = $urandom_range(8, 60);
		end else begin
			ready_hold--;
		end
		case (ready_mode)
			0:       result_ready <= 1'b1;
			1:       result_ready <= ($urandom_range(0, 1) == 1);
			default: result_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// Item side: one transfer. Items go out in bursts of random length; a
	// random gap (sometimes none) comes before each new burst. Valid is raised
	// right after an edge and held until the edge where ready is seen high.
	task automatic send_item(input data_t v, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		item_valid <= 1'b1;
		item       <= '{value: v, last: l};
		do @(posedge clk); while (!item_ready);
		account_item('{value: v, last: l});
	endtask

	task automatic send_batch(input data_t vals[$]);
		foreach (vals[k])
			send_item(vals[k], k == vals.size() - 1);
	endtask

	// Mix of field extremes, a narrow band around zero (many repeats) and
	// full-width random words.
	function automatic data_t pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return data_t'($urandom_range(0, 6)) - 3;
			default: return data_t'($urandom);
		endcase
	endfunction

	// A batch of one: the only value is also the final one.
	task automatic test_single_value();
		send_item(32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic test_field_extremes();
		send_batch('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE});
	endtask

	// Repeats of 5 and of -3, plus the most negative value.
	task automatic test_duplicates();
		send_batch('{32'd5, 32'd5, -32'sd3, 32'd5, -32'sd3, 32'h8000_0000});
	endtask

	// Already ordered and reverse ordered input.
	task automatic test_ordered_runs();
		send_batch('{-32'sd2, -32'sd1, 32'd0, 32'd1, 32'd2});
		send_batch('{32'd40, 32'd30, 32'd20, 32'd10, -32'sd10});
	endtask

	// Store full: one batch that fills the store and then overruns it, so
	// its tail, including the value of the item marked last, is dropped.
	task automatic test_store_full();
		data_t vals[$];
		repeat (DEPTH + 3) vals.push_back(pick_value());
		send_batch(vals);
	endtask

	// Random batches, mostly short so many batch boundaries are exercised.
	task automatic test_random_batches();
		data_t vals[$];
		int    sent;
		int    len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
			vals.delete();
			repeat (len) vals.push_back(pick_value());
			send_batch(vals);
			sent += len;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_single_value();
		test_field_extremes();
		test_duplicates();
		test_ordered_runs();
		test_store_full();
		test_random_batches();

		// Every batch ends with a last item, so the owed results empty out
		// once the final drain completes.
		item_valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
rtl/qss_pkg.sv
rtl/qss_cell.sv
rtl/quicksort_sorter_unit.sv
tb/sv/quicksort_sorter_unit_test.sv
